/* design/bh288_pkg.sv */
// package for the 288-bit block hash unit
// holds sizes, the initial chaining value, rotate helpers and shared types
// no dependencies
package bh288_pkg;

  localparam int BLOCK_BYTES = 72;
  localparam int BLOCK_WORDS = 18;
  localparam int CHAIN_WORDS = 9;
  localparam int ROUNDS      = 64;
  localparam int CNT_W       = 7;
  localparam int ROUND_W     = 6;
  localparam int NUM_W       = 4;
  localparam int OUT_TDATA_W = 40;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [CNT_W-1:0] LAST_BYTE_POS = CNT_W'(BLOCK_BYTES - 1);
  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);
  localparam logic [NUM_W-1:0] LAST_NUM = NUM_W'(CHAIN_WORDS - 1);

  localparam logic [31:0] IV [CHAIN_WORDS] = '{
    32'h243F6A88, 32'h85A308D3, 32'h13198A2E, 32'h03707344, 32'hA4093822,
    32'h299F31D0, 32'h082EFA98, 32'hEC4E6C89, 32'h452821E6
  };

  typedef logic [BLOCK_WORDS-1:0][31:0] bh288_block_t;

  typedef struct packed {
    logic         compress;
    logic         emit;
    bh288_block_t block;
  } bh288_cmd_t;

  typedef struct packed {
    logic valid;
    logic full;
  } bh288_qstat_t;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_ROUND,
    BACK_FINAL,
    BACK_EMIT
  } bh288_state_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
    logic [63:0] w;
    w = {v, v} << r;
    return w[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] r);
    logic [63:0] w;
    w = {v, v} >> r;
    return w[31:0];
  endfunction

endpackage

/* design/bh288_front.sv */
// front part: takes byte and finish words, packs bytes into the block buffer
// and pushes compress / emit commands; depends on bh288_pkg
module bh288_front
  import bh288_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,  // data_byte
  input  logic       s_tuser,  // kind
  input  bh288_qstat_t qstat,
  output logic       push,
  output bh288_cmd_t cmd
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [7:0]       byte_buf [BLOCK_BYTES];
  logic [7:0]       blk_bytes [BLOCK_BYTES];
  logic             accept;

  assign s_tready = !qstat.full;
  assign accept   = s_tvalid && s_tready;

  // padded or completed block as it would be pushed this cycle
  always_comb begin
    for (int p = 0; p < BLOCK_BYTES; p++) begin
      if (CNT_W'(p) < count) begin
        blk_bytes[p] = byte_buf[p];
      end else if (CNT_W'(p) == count) begin
        blk_bytes[p] = s_tuser ? PAD_BYTE : s_tdata;
      end else begin
        blk_bytes[p] = 8'h00;
      end
    end
    for (int w = 0; w < BLOCK_WORDS; w++) begin
      cmd.block[w] = {blk_bytes[4*w], blk_bytes[4*w+1], blk_bytes[4*w+2], blk_bytes[4*w+3]};
    end
    cmd.compress = s_tuser ? (count != '0) : 1'b1;
    cmd.emit     = s_tuser;
    push         = accept && (s_tuser || (count == LAST_BYTE_POS));
  end

  always_comb begin
    count_next = count;
    if (accept) begin
      if (s_tuser || (count == LAST_BYTE_POS)) begin
        count_next = '0;
      end else begin
        count_next = count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !s_tuser) begin
      byte_buf[count] <= s_tdata;
    end
  end

endmodule

/* design/bh288_queue.sv */
// two-entry command queue between front and back
// depends on bh288_pkg
module bh288_queue
  import bh288_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  bh288_cmd_t   push_cmd,
  input  logic         pop,
  output bh288_cmd_t   head,
  output bh288_qstat_t qstat
);

  bh288_cmd_t  entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;

  assign head        = entries[rd_ptr];
  assign qstat.valid = (fill != 2'd0);
  assign qstat.full  = (fill == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

/* design/bh288_back.sv */
// back part: 64-round compression on rotating chain and block rings,
// final feed-forward and digest emission; depends on bh288_pkg
module bh288_back
  import bh288_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  bh288_qstat_t qstat,
  input  bh288_cmd_t   head,
  output logic         pop,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // digest_word, word_number, zero fill
  output logic         m_tlast             // last_word
);

  bh288_state_t       state;
  bh288_state_t       state_next;
  logic [31:0]        chain [CHAIN_WORDS];
  logic [31:0]        mring [BLOCK_WORDS];
  logic [ROUND_W-1:0] rnd;
  logic [ROUND_W-1:0] r9;
  logic [3:0]         c10;
  logic               emit_pend;
  logic [NUM_W-1:0]   word_num;
  logic [ROUND_W-1:0] lag;
  logic [ROUND_W-1:0] rr;
  logic [31:0]        m_sel;
  logic [31:0]        f1;
  logic [31:0]        f2;
  logic [31:0]        new_word;
  logic               out_take;

  assign out_take = m_tvalid && m_tready;

  // round datapath, ring taps are fixed per role
  always_comb begin
    lag = rnd - r9;
    case (lag[2:0])
      3'd0:    m_sel = mring[0];
      3'd1:    m_sel = mring[17];
      3'd2:    m_sel = mring[16];
      3'd3:    m_sel = mring[15];
      3'd4:    m_sel = mring[14];
      3'd5:    m_sel = mring[13];
      3'd6:    m_sel = mring[12];
      default: m_sel = mring[11];
    endcase
    if (rnd >= ROUND_W'(58)) begin
      rr = rnd - ROUND_W'(58);
    end else if (rnd >= ROUND_W'(29)) begin
      rr = rnd - ROUND_W'(29);
    end else begin
      rr = rnd;
    end
    f1       = (chain[1] ^ mring[0]) ^ rotl32(chain[4], r9[4:0]);
    f2       = (chain[5] + m_sel) ^ rotr32(chain[7], rr[4:0]);
    new_word = f1 + f2 + chain[0];
  end

  always_comb begin
    state_next = state;
    case (state)
      BACK_IDLE: begin
        if (qstat.valid) begin
          state_next = head.compress ? BACK_ROUND : BACK_EMIT;
        end
      end
      BACK_ROUND: begin
        if (rnd == LAST_ROUND) begin
          state_next = BACK_FINAL;
        end
      end
      BACK_FINAL: begin
        state_next = emit_pend ? BACK_EMIT : BACK_IDLE;
      end
      BACK_EMIT: begin
        if (out_take && (word_num == LAST_NUM)) begin
          state_next = BACK_IDLE;
        end
      end
      default: state_next = BACK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    m_tvalid = 1'b0;
    case (state)
      BACK_IDLE:  pop = qstat.valid;
      BACK_EMIT:  m_tvalid = 1'b1;
      default: begin
        pop      = 1'b0;
        m_tvalid = 1'b0;
      end
    endcase
  end

  assign m_tdata = {{(OUT_TDATA_W - 32 - NUM_W){1'b0}}, word_num, chain[0]};
  assign m_tlast = (word_num == LAST_NUM);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BACK_IDLE;
      rnd       <= '0;
      r9        <= '0;
      c10       <= '0;
      emit_pend <= 1'b0;
      word_num  <= '0;
      for (int i = 0; i < CHAIN_WORDS; i++) begin
        chain[i] <= IV[i];
      end
    end else begin
      state <= state_next;
      case (state)
        BACK_IDLE: begin
          rnd       <= '0;
          r9        <= '0;
          c10       <= '0;
          word_num  <= '0;
          emit_pend <= head.emit;
        end
        BACK_ROUND: begin
          rnd <= rnd + 1'b1;
          c10 <= (c10 == 4'd9) ? 4'd0 : c10 + 4'd1;
          if (c10 != 4'd0) begin
            r9 <= r9 + 1'b1;
          end
          for (int i = 0; i < CHAIN_WORDS - 1; i++) begin
            chain[i] <= chain[i+1];
          end
          chain[CHAIN_WORDS-1] <= new_word;
        end
        BACK_FINAL: begin
          // ring is one ahead after the last round: realign and feed forward
          for (int i = 0; i < CHAIN_WORDS; i++) begin
            chain[i] <= chain[(i + CHAIN_WORDS - 1) % CHAIN_WORDS] ^ mring[i + 8];
          end
        end
        BACK_EMIT: begin
          if (out_take) begin
            word_num <= word_num + 1'b1;
            if (word_num == LAST_NUM) begin
              for (int i = 0; i < CHAIN_WORDS; i++) begin
                chain[i] <= IV[i];
              end
            end else begin
              for (int i = 0; i < CHAIN_WORDS - 1; i++) begin
                chain[i] <= chain[i+1];
              end
              chain[CHAIN_WORDS-1] <= chain[0];
            end
          end
        end
        default: begin
          rnd <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.compress) begin
      for (int j = 0; j < BLOCK_WORDS; j++) begin
        mring[j] <= head.block[j];
      end
    end else if (state == BACK_ROUND) begin
      for (int j = 0; j < BLOCK_WORDS - 1; j++) begin
        mring[j] <= mring[j+1];
      end
      mring[BLOCK_WORDS-1] <= mring[0];
    end
  end

endmodule

/* design/block_hash_288bit_unit.sv */
// top level of the 288-bit block hash unit
// depends on bh288_pkg, bh288_front, bh288_queue, bh288_back
//
// input stream: one word per item, tuser = kind (0 byte, 1 finish),
// tdata = message byte. bytes are packed big-endian into 72-byte blocks.
// output stream: nine digest words per finish, tdata[31:0] digest word,
// tdata[35:32] word number, tlast on word 8.
// the front accepts one word per cycle while the two-entry command queue
// has room; a full block or a finish pushes one command.
// the back fetches each block from the queue, runs the rounds at one round a
// cycle and then does the feed-forward, so it keeps up with one byte per cycle on
// long messages. with the back idle, a finish gives its first digest word after
// the rounds and the feed-forward of its partial block (straight after the fetch
// with no partial block), then one word per cycle while the receiver takes them.
// when the receiver stalls the back holds its word; the front keeps filling
// the next block and the queue until it is full.
// reset clears the byte count, the queue and the state machine and loads
// the initial chaining value.
module block_hash_288bit_unit
  import bh288_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,  // data_byte
  input  logic                   s_tuser,  // kind
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // digest_word, word_number, zero fill
  output logic                   m_tlast   // last_word
);

  logic         push;
  logic         pop;
  bh288_cmd_t   push_cmd;
  bh288_cmd_t   head;
  bh288_qstat_t qstat;

  bh288_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .qstat    (qstat),
    .push     (push),
    .cmd      (push_cmd)
  );

  bh288_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .qstat    (qstat)
  );

  bh288_back u_back (
    .clk      (clk),
    .rst      (rst),
    .qstat    (qstat),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("command pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.valid)
    else $error("command popped from empty queue");

  a_last_number: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[35:32] == LAST_NUM))
    else $error("tlast on wrong digest word");

  a_digest_ends: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
    else $error("output still valid after final digest word");

endmodule
